[rtl/core/fdcp_pkg.sv]
// shared constants for the framed decimal command parser
// byte codes, field widths and the default frame length; no dependencies
package fdcp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 16;

   // default number of characters a frame may carry
   localparam int unsigned MAX_CHARS_DEFAULT = 4;

   localparam logic [BYTE_W-1:0] BYTE_START   = 8'h53; // 'S'
   localparam logic [BYTE_W-1:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_MINUS   = 8'h2D; // '-'
   localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h30; // '0'

endpackage

[rtl/core/framed_decimal_command_parser.sv]
// framed decimal command parser: input register, frame update, result register
// an accepted item waits in the input register until processed; a closed frame's command is registered as the result
// throughput: one item per cycle, stalls only while a result waits and rsp_tready is low
// reset: synchronous, active high; clears handshake state and returns the parser to idle
// depends on fdcp_pkg
module framed_decimal_command_parser #(
   parameter int unsigned MAX_CHARS = fdcp_pkg::MAX_CHARS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fdcp_pkg::BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fdcp_pkg::VALUE_W-1:0]    rsp_tdata    // [15:0] command_value (signed)
);

   localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

   // input register
   logic [fdcp_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                         byte_vld_ff, byte_vld_in;

   // frame state
   logic                         in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]             char_count_ff, char_count_in;
   logic [fdcp_pkg::VALUE_W-1:0] value_acc_ff, value_acc_in;
   logic                         negative_ff, negative_in;

   // result register
   logic signed [fdcp_pkg::VALUE_W-1:0] result_ff, result_in;
   logic                                out_vld_ff, out_vld_in;

   logic                         advance;
   logic                         process;
   logic                         emit;
   logic [fdcp_pkg::BYTE_W-1:0]  digit;
   logic [fdcp_pkg::VALUE_W-1:0] acc_next;

   assign advance    = !out_vld_ff || rsp_tready;
   assign process    = byte_vld_ff && advance;
   assign req_tready = !byte_vld_ff || advance;

   // acc*10 as two shifts and an add, wraps modulo 2^16
   assign digit    = (byte_ff == fdcp_pkg::BYTE_MINUS) ? '0 : byte_ff - fdcp_pkg::BYTE_ZERO;
   assign acc_next = (value_acc_ff << 3) + (value_acc_ff << 1)
                     + fdcp_pkg::VALUE_W'(digit);

   always_comb begin
      in_frame_in   = in_frame_ff;
      char_count_in = char_count_ff;
      value_acc_in  = value_acc_ff;
      negative_in   = negative_ff;
      emit          = 1'b0;
      if (process) begin
         if (!in_frame_ff) begin
            if (byte_ff == fdcp_pkg::BYTE_START) begin
               in_frame_in   = 1'b1;
               char_count_in = '0;
               value_acc_in  = '0;
               negative_in   = 1'b0;
            end
         end else begin
            priority if (byte_ff == fdcp_pkg::BYTE_START) begin
               // start byte inside a frame is dropped
            end else if (byte_ff == fdcp_pkg::BYTE_NEWLINE) begin
               emit          = 1'b1;
               in_frame_in   = 1'b0;
               char_count_in = '0;
            end else if (char_count_ff >= CNT_MAX) begin
               // overlong frame, abort quietly
               in_frame_in   = 1'b0;
               char_count_in = '0;
            end else begin
               value_acc_in  = acc_next;
               char_count_in = char_count_ff + CNT_W'(1);
               if (byte_ff == fdcp_pkg::BYTE_MINUS) begin
                  negative_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      byte_in     = byte_ff;
      byte_vld_in = byte_vld_ff;
      if (req_tvalid && req_tready) begin
         byte_in     = req_tdata;
         byte_vld_in = 1'b1;
      end else if (process) begin
         byte_vld_in = 1'b0;
      end
   end

   always_comb begin
      result_in  = result_ff;
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = emit;
         if (emit) begin
            result_in = negative_ff ? -$signed(value_acc_ff) : $signed(value_acc_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff   <= 1'b0;
         in_frame_ff   <= 1'b0;
         char_count_ff <= '0;
         value_acc_ff  <= '0;
         negative_ff   <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         byte_vld_ff   <= byte_vld_in;
         in_frame_ff   <= in_frame_in;
         char_count_ff <= char_count_in;
         value_acc_ff  <= value_acc_in;
         negative_ff   <= negative_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = result_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      char_count_ff <= CNT_MAX)
      else $error("character count beyond frame limit");

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> char_count_ff == '0)
      else $error("character count not cleared while idle");

   a_frame_opens_on_start: assert property (@(posedge clock) disable iff (reset)
      $rose(in_frame_ff) |-> $past(byte_ff) == fdcp_pkg::BYTE_START)
      else $error("frame opened by a byte other than start");

   a_emit_reaches_output: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_tvalid)
      else $error("closed frame produced no result");

endmodule
